// ===== sv/wsw_pkg.sv =====
// Shared types and constants of the windowed service watchdog.
package wsw_pkg;

	// Fixed field widths
	localparam int unsigned NOW_WIDTH     = 32;
	localparam int unsigned TIMEOUT_WIDTH = 24;
	localparam int unsigned OP_WIDTH      = 3;
	localparam int unsigned BYTE_WIDTH    = 8;
	localparam int unsigned CFG_IDX_WIDTH = 2;
	localparam int unsigned CFG_DATA_WIDTH = TIMEOUT_WIDTH;

	// Command characters carried in written bytes
	localparam logic [BYTE_WIDTH-1:0] CHAR_DISABLE = 8'h56; // 'V'
	localparam logic [BYTE_WIDTH-1:0] CHAR_LONG    = 8'h54; // 'T'

	// Register defaults after reset
	localparam logic [TIMEOUT_WIDTH-1:0] SHORT_TIMEOUT_RESET = 24'd6000;
	localparam logic [TIMEOUT_WIDTH-1:0] LONG_TIMEOUT_RESET  = 24'd30000;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_CHECK     = 3'd0,
		OP_OPEN      = 3'd1,
		OP_WRITE     = 3'd2,
		OP_KEEPALIVE = 3'd3,
		OP_RELEASE   = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_KERNEL_ONLY   = 2'd0,
		CFG_SHORT_TIMEOUT = 2'd1,
		CFG_LONG_TIMEOUT  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                     kernel_only;
		logic [TIMEOUT_WIDTH-1:0] short_timeout_ticks;
		logic [TIMEOUT_WIDTH-1:0] long_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic kick;
		logic expired;
		logic status;
	} result_t;

endpackage

// ===== sv/windowed_service_watchdog_unit.sv =====
// Top level of the windowed service watchdog: handshake stages and registers.
//
//  channel  | direction | handshake                 | beat carries
//  ---------+-----------+---------------------------+----------------------------------
//  item     | in        | item_valid / item_stall   | op, now, data_byte, last_byte
//  result   | out       | result_valid / result_stall | kick, expired, status
//  cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle while the result channel does not stall; an item passes the
// input stage, then the result register. The state update and the window compare sit between them.
// Reset clears the watchdog state and loads the register defaults.
// A stalled result holds; the input stage then holds its beat and stalls the
// item channel. cfg_ready is always high.
module windowed_service_watchdog_unit
	import wsw_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [OP_WIDTH-1:0]       op,
	input  logic [NOW_WIDTH-1:0]      now,
	input  logic [BYTE_WIDTH-1:0]     data_byte,
	input  logic                      last_byte,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic                      kick,
	output logic                      expired,
	output logic                      status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic [OP_WIDTH-1:0]   op_s1;
	logic [NOW_WIDTH-1:0]  now_s1;
	logic [BYTE_WIDTH-1:0] byte_s1;
	logic                  last_s1;
	logic                  advance;
	logic                  result_valid_q;
	result_t               res_d;
	result_t               res_q;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_only         <= 1'b0;
			cfg_q.short_timeout_ticks <= SHORT_TIMEOUT_RESET;
			cfg_q.long_timeout_ticks  <= LONG_TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KERNEL_ONLY:   cfg_q.kernel_only         <= cfg_data[0];
				CFG_SHORT_TIMEOUT: cfg_q.short_timeout_ticks <= cfg_data;
				CFG_LONG_TIMEOUT:  cfg_q.long_timeout_ticks  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the input stage when the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1   <= op;
			now_s1  <= now;
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	wsw_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cfg      (cfg_q),
		.op       (op_s1),
		.now      (now_s1),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.res      (res_d)
	);

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign kick         = res_q.kick;
	assign expired      = res_q.expired;
	assign status       = res_q.status;

endmodule

// ===== sv/wsw_core.sv =====
// Watchdog state registers and the per-item evaluation of one operation.
module wsw_core
	import wsw_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  cfg_t                  cfg,
	input  logic [OP_WIDTH-1:0]   op,
	input  logic [NOW_WIDTH-1:0]  now,
	input  logic [BYTE_WIDTH-1:0] data_byte,
	input  logic                  last_byte,
	output result_t               res
);

	logic [TIME_WIDTH-1:0] window_start_q, window_start_d;
	logic [TIME_WIDTH-1:0] window_end_q, window_end_d;
	logic                  service_required_q, service_required_d;
	logic                  long_mode_q, long_mode_d;
	logic                  warned_q, warned_d;
	logic                  held_open_q, held_open_d;

	logic [TIME_WIDTH+NOW_WIDTH-1:0]     now_ext;
	logic [TIME_WIDTH+TIMEOUT_WIDTH-1:0] len_ext;
	logic [TIME_WIDTH-1:0]               t;
	logic [TIME_WIDTH-1:0]               len;
	logic                                alive;
	logic                                restart;

	// Take the tick count modulo the time width
	assign now_ext = {{TIME_WIDTH{1'b0}}, now};
	assign t       = now_ext[TIME_WIDTH-1:0];

	// Wrap-aware window test
	always_comb begin
		if (window_end_q < window_start_q) begin
			alive = (t < window_end_q) || (t >= window_start_q);
		end else begin
			alive = (t >= window_start_q) && (t < window_end_q);
		end
	end

	// Decode the operation, then restart the window with the updated mode
	always_comb begin
		service_required_d = service_required_q;
		long_mode_d        = long_mode_q;
		warned_d           = warned_q;
		held_open_d        = held_open_q;
		window_start_d     = window_start_q;
		window_end_d       = window_end_q;
		restart            = 1'b0;
		res                = '0;

		unique case (op_t'(op))
			OP_CHECK: begin
				if (cfg.kernel_only || !service_required_q || alive) begin
					res.kick = 1'b1;
				end else if (!warned_q) begin
					warned_d    = 1'b1;
					res.expired = 1'b1;
				end
			end
			OP_OPEN: begin
				if (held_open_q) begin
					res.status = 1'b1;
				end else begin
					held_open_d        = 1'b1;
					service_required_d = 1'b1;
					long_mode_d        = 1'b0;
					restart            = 1'b1;
				end
			end
			OP_WRITE: begin
				if (data_byte == CHAR_DISABLE) begin
					service_required_d = 1'b0;
				end else if (data_byte == CHAR_LONG) begin
					long_mode_d = 1'b1;
				end
				restart = last_byte;
			end
			OP_KEEPALIVE: begin
				restart = 1'b1;
			end
			OP_RELEASE: begin
				held_open_d = 1'b0;
			end
			default: begin
			end
		endcase

		len_ext = {{TIME_WIDTH{1'b0}},
			long_mode_d ? cfg.long_timeout_ticks : cfg.short_timeout_ticks};
		len     = len_ext[TIME_WIDTH-1:0];
		if (restart) begin
			window_start_d = t;
			window_end_d   = t + len;
			warned_d       = 1'b0;
		end
	end

	// Commit state when an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q     <= '0;
			window_end_q       <= '0;
			service_required_q <= 1'b0;
			long_mode_q        <= 1'b0;
			warned_q           <= 1'b0;
			held_open_q        <= 1'b0;
		end else if (step) begin
			window_start_q     <= window_start_d;
			window_end_q       <= window_end_d;
			service_required_q <= service_required_d;
			long_mode_q        <= long_mode_d;
			warned_q           <= warned_d;
			held_open_q        <= held_open_d;
		end
	end

endmodule

// ===== sv/wsw_checker.sv =====
// Port-level checks of the windowed service watchdog, bound to the top level.
module wsw_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_stall,
	input logic kick,
	input logic expired,
	input logic status
);

	// A check either kicks or expires, never both
	a_kick_excl_expired: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(kick && expired))
		else $error("kick and expired on the same beat");

	// A refused open carries no check outcome
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status) |-> (!kick && !expired))
		else $error("status set together with kick or expired");

	// A stalled result stays valid
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its fields
	a_fields_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> ($stable(kick) && $stable(expired) && $stable(status)))
		else $error("result changed while stalled");

endmodule

bind windowed_service_watchdog_unit wsw_checker u_wsw_checker (.*);

// ===== sim/wsw_watchdog_checker.sv =====
// Watchdog result checker: predicts each result beat from accepted item beats and compares.
module wsw_watchdog_checker
	import wsw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic                      item_stall,
	input  logic [OP_WIDTH-1:0]       op,
	input  logic [NOW_WIDTH-1:0]      now,
	input  logic [BYTE_WIDTH-1:0]     data_byte,
	input  logic                      last_byte,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  logic                      kick,
	input  logic                      expired,
	input  logic                      status,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
	output int unsigned               mismatches,
	output int unsigned               in_flight
);

	// Shadow copy of the watchdog registers and state
	cfg_t                 wd_cfg;
	logic [NOW_WIDTH-1:0] win_start;
	logic [NOW_WIDTH-1:0] win_end;
	logic                 svc_required;
	logic                 long_sel;
	logic                 warned;
	logic                 held;

	result_t expected_results[$];

	// Alive test over a window that may wrap past zero
	function automatic logic window_alive(input logic [NOW_WIDTH-1:0] t);
		if (win_end < win_start)
			return (t < win_end) || (t >= win_start);
		return (t >= win_start) && (t < win_end);
	endfunction

	// Restart the service window at time t and clear the warning
	function automatic void restart_window(input logic [NOW_WIDTH-1:0] t);
		logic [TIMEOUT_WIDTH-1:0] len;
		len = long_sel ? wd_cfg.long_timeout_ticks : wd_cfg.short_timeout_ticks;
		win_start = t;
		win_end   = t + NOW_WIDTH'(len);
		warned    = 1'b0;
	endfunction

	// Advance the shadow state by one item and return the result it causes
	function automatic result_t service_step(
		input logic [OP_WIDTH-1:0]   code,
		input logic [NOW_WIDTH-1:0]  t,
		input logic [BYTE_WIDTH-1:0] ch,
		input logic                  last
	);
		result_t r;
		r = '0;
		case (code)
			OP_CHECK: begin
				if (wd_cfg.kernel_only || !svc_required || window_alive(t)) begin
					r.kick = 1'b1;
				end else if (!warned) begin
					warned    = 1'b1;
					r.expired = 1'b1;
				end
			end
			OP_OPEN: begin
				if (held) begin
					r.status = 1'b1;
				end else begin
					held         = 1'b1;
					svc_required = 1'b1;
					long_sel     = 1'b0;
					restart_window(t);
				end
			end
			OP_WRITE: begin
				if (ch == CHAR_DISABLE)
					svc_required = 1'b0;
				else if (ch == CHAR_LONG)
					long_sel = 1'b1;
				if (last)
					restart_window(t);
			end
			OP_KEEPALIVE: restart_window(t);
			OP_RELEASE:   held = 1'b0;
			default: ;
		endcase
		return r;
	endfunction

	// Track register writes, predict on item beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin : watch
		result_t     exp_r;
		int unsigned bad;
		if (!arst_n) begin
			wd_cfg.kernel_only         = 1'b0;
			wd_cfg.short_timeout_ticks = SHORT_TIMEOUT_RESET;
			wd_cfg.long_timeout_ticks  = LONG_TIMEOUT_RESET;
			win_start    = '0;
			win_end      = '0;
			svc_required = 1'b0;
			long_sel     = 1'b0;
			warned       = 1'b0;
			held         = 1'b0;
			expected_results.delete();
			mismatches <= 0;
			in_flight  <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KERNEL_ONLY:   wd_cfg.kernel_only = cfg_data[0];
					CFG_SHORT_TIMEOUT: wd_cfg.short_timeout_ticks = cfg_data;
					CFG_LONG_TIMEOUT:  wd_cfg.long_timeout_ticks = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no prediction pending");
					bad++;
				end else begin
					exp_r = expected_results.pop_front();
					if (kick !== exp_r.kick) begin
						$error("kick: expected %0d, got %0d", exp_r.kick, kick);
						bad++;
					end
					if (expired !== exp_r.expired) begin
						$error("expired: expected %0d, got %0d", exp_r.expired, expired);
						bad++;
					end
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						bad++;
					end
				end
			end
			if (item_valid && !item_stall)
				expected_results.push_back(service_step(op, now, data_byte, last_byte));
			mismatches <= mismatches + bad;
			in_flight  <= expected_results.size();
		end
	end

endmodule

// ===== sim/tb_windowed_service_watchdog_unit.sv =====
// Testbench top of the windowed service watchdog: stimulus, idling and verdict.
module tb_windowed_service_watchdog_unit
	import wsw_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned ITEMS_PER_PHASE = 250;

	localparam logic [OP_WIDTH-1:0]       OP_RSVD_FIRST = 3'd5;
	localparam logic [OP_WIDTH-1:0]       OP_RSVD_LAST  = 3'd7;
	localparam logic [CFG_IDX_WIDTH-1:0]  CFG_UNMAPPED  = 2'd3;
	localparam logic [BYTE_WIDTH-1:0]     CHAR_PLAIN    = 8'h41;
	localparam logic [NOW_WIDTH-1:0]      WRAP_START    = 32'hFFFF_FF00;
	localparam logic [CFG_DATA_WIDTH-1:0] TIMEOUT_MAX   = 24'hFF_FFFF;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      item_valid   = 1'b0;
	logic                      item_stall;
	logic [OP_WIDTH-1:0]       op           = '0;
	logic [NOW_WIDTH-1:0]      now          = '0;
	logic [BYTE_WIDTH-1:0]     data_byte    = '0;
	logic                      last_byte    = 1'b0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic                      kick;
	logic                      expired;
	logic                      status;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index    = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data     = '0;

	int unsigned          mismatches;
	int unsigned          in_flight;
	int unsigned          cycles      = 0;
	bit                   idle_item   = 1'b1;
	bit                   idle_result = 1'b1;
	logic [NOW_WIDTH-1:0] tick        = '0;

	windowed_service_watchdog_unit uut (.*);

	wsw_watchdog_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stall the result channel at random before each beat while result idling is on
	initial begin : result_sink
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = idle_result ? $urandom_range(0, 4) : 0;
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// Send one item beat, after a random gap while item idling is on, and hold it until accepted
	task automatic push_item(
		input logic [OP_WIDTH-1:0]   code,
		input logic [NOW_WIDTH-1:0]  t_now,
		input logic [BYTE_WIDTH-1:0] ch,
		input logic                  last
	);
		int unsigned gap;
		gap = idle_item ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op         <= code;
		now        <= t_now;
		data_byte  <= ch;
		last_byte  <= last;
		do @(posedge clk); while (item_stall);
	endtask

	// Write one register; the caller drops cfg_valid after the last write
	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain every pending result, then let the pipeline empty
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One random item: time mostly walks forward on the scale of the timeouts
	task automatic random_item(input int unsigned span);
		int unsigned          pick;
		int unsigned          step;
		logic [OP_WIDTH-1:0]  code;
		logic [BYTE_WIDTH-1:0] ch;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			step = 0;
		else if (pick <= 5)
			step = $urandom_range(0, span / 2);
		else if (pick <= 8)
			step = $urandom_range(span / 2, 2 * span);
		else begin
			tick = $urandom();
			step = 0;
		end
		tick = tick + step;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			code = OP_CHECK;
		else if (pick < 65)
			code = OP_WRITE;
		else if (pick < 75)
			code = OP_KEEPALIVE;
		else if (pick < 87)
			code = OP_OPEN;
		else if (pick < 95)
			code = OP_RELEASE;
		else
			code = OP_RSVD_FIRST
				+ OP_WIDTH'($urandom_range(0, OP_RSVD_LAST - OP_RSVD_FIRST));
		pick = $urandom_range(0, 19);
		if (pick < 3)
			ch = CHAR_DISABLE;
		else if (pick < 8)
			ch = CHAR_LONG;
		else
			ch = BYTE_WIDTH'($urandom_range(0, 255));
		push_item(code, tick, ch, 1'($urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		logic                      ko_set;
		logic [CFG_DATA_WIDTH-1:0] short_set;
		logic [CFG_DATA_WIDTH-1:0] long_set;
		int unsigned               span;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults, wrapped window, busy open, single warning
		push_item(OP_CHECK, 32'h0, 8'h00, 1'b0);
		push_item(OP_OPEN, WRAP_START, 8'h00, 1'b0);
		push_item(OP_OPEN, 32'h0, 8'h00, 1'b0);
		push_item(OP_CHECK, WRAP_START, 8'h00, 1'b0);
		push_item(OP_CHECK, 32'hFFFF_FFFF, 8'h00, 1'b0);
		push_item(OP_CHECK, 32'h0, 8'h00, 1'b0);
		push_item(OP_CHECK, WRAP_START + SHORT_TIMEOUT_RESET - 1, 8'h00, 1'b0);
		push_item(OP_CHECK, WRAP_START + SHORT_TIMEOUT_RESET, 8'h00, 1'b0);
		push_item(OP_CHECK, WRAP_START + SHORT_TIMEOUT_RESET, 8'h00, 1'b0);
		push_item(OP_CHECK, 32'h8000_0000, 8'h00, 1'b0);
		// Keepalive, then a check just before the new start
		push_item(OP_KEEPALIVE, 32'd100, 8'h00, 1'b0);
		push_item(OP_CHECK, 32'd99, 8'h00, 1'b0);
		// Long mode selected by a written byte, window restarted on the last byte
		push_item(OP_WRITE, 32'd200, CHAR_LONG, 1'b0);
		push_item(OP_WRITE, 32'd1000, CHAR_PLAIN, 1'b1);
		push_item(OP_CHECK, 32'd1000 + LONG_TIMEOUT_RESET - 1, 8'h00, 1'b0);
		push_item(OP_CHECK, 32'd1000 + LONG_TIMEOUT_RESET, 8'h00, 1'b0);
		// Servicing off, then release and reopen
		push_item(OP_WRITE, 32'h0, CHAR_DISABLE, 1'b0);
		push_item(OP_CHECK, 32'hFFFF_FFFF, 8'h00, 1'b0);
		push_item(OP_RELEASE, 32'h0, 8'h00, 1'b0);
		push_item(OP_OPEN, 32'h0, 8'h00, 1'b0);
		push_item(OP_CHECK, 32'h7FFF_FFFF, 8'h00, 1'b0);
		push_item(OP_WRITE, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		push_item(OP_WRITE, 32'h0, 8'h00, 1'b1);
		// Reserved opcodes change nothing
		push_item(OP_RSVD_FIRST, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		push_item(OP_RSVD_FIRST + 3'd1, 32'h0, 8'h00, 1'b0);
		push_item(OP_RSVD_LAST, 32'h5555_AAAA, CHAR_DISABLE, 1'b1);
		push_item(OP_RELEASE, 32'h0, 8'h00, 1'b0);

		// Random phases, each under its own register setting
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin ko_set = 1'b0; short_set = 24'd200;     long_set = 24'd3000;    end
				1: begin ko_set = 1'b1; short_set = 24'd500;     long_set = 24'd500;     end
				2: begin ko_set = 1'b0; short_set = 24'd1;       long_set = TIMEOUT_MAX; end
				3: begin ko_set = 1'b0; short_set = TIMEOUT_MAX; long_set = 24'd1;       end
				4: begin ko_set = 1'b0; short_set = 24'd0;       long_set = 24'd50;      end
				5: begin
					ko_set    = 1'b0;
					short_set = CFG_DATA_WIDTH'($urandom_range(1, 5000));
					long_set  = CFG_DATA_WIDTH'($urandom_range(1, 50000));
				end
				6: begin ko_set = 1'b1; short_set = TIMEOUT_MAX; long_set = TIMEOUT_MAX; end
				default: begin
					ko_set    = 1'b0;
					short_set = SHORT_TIMEOUT_RESET;
					long_set  = LONG_TIMEOUT_RESET;
				end
			endcase
			settle();
			write_reg(CFG_KERNEL_ONLY, {{(CFG_DATA_WIDTH-1){1'b0}}, ko_set});
			write_reg(CFG_SHORT_TIMEOUT, short_set);
			write_reg(CFG_LONG_TIMEOUT, long_set);
			if (phase % 2 == 1)
				write_reg(CFG_UNMAPPED, CFG_DATA_WIDTH'($urandom()));
			cfg_valid <= 1'b0;

			idle_item   = !(phase % 4 == 1 || phase == 7);
			idle_result = !(phase % 4 == 2 || phase == 7);
			span = (short_set > long_set) ? 32'(short_set) : 32'(long_set);
			if (span < 4)
				span = 4;
			if (phase % 2 == 0)
				tick = 32'hFFFF_FFFF - $urandom_range(0, span);
			else
				tick = $urandom();
			repeat (ITEMS_PER_PHASE) random_item(span);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
